>>> design/assert_macros.svh
// Assertion macros shared by the RTL of the gradient descent unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define LRGD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define LRGD_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LRGD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRGD_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> design/lrgd_pkg.sv
// Shared types, constants and fixed-point helpers of the gradient descent unit.
`default_nettype none
package lrgd_pkg;

  localparam int IDX_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EPOCHS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_TOLERANCE = 2'd2;

  localparam logic [15:0] LR_RESET = 16'd655;
  localparam logic [15:0] EPOCHS_RESET = 16'd1000;
  localparam logic [31:0] TOL_RESET = 32'd1;

  // Control word that the sequencer broadcasts to every cell of the chain.
  typedef struct packed {
    logic clear_w;
    logic shift_wg;
    logic clear_g;
    logic grad;
    logic shift_x;
    logic mul;
    logic shift_p;
  } cell_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/lrgd_if.sv
// Valid/ready channel interfaces for the sample stream and the result stream.
`default_nettype none
interface lrgd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] feature_value;
  logic signed [31:0] target_value;
  logic               row_end;
  logic               set_end;
  modport source (output valid, feature_value, target_value, row_end, set_end,
                  input ready);
  modport sink (input valid, feature_value, target_value, row_end, set_end,
                output ready);
endinterface

interface lrgd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coefficient;
  logic [6:0]         coefficient_index;
  logic [15:0]        epochs_used;
  logic               stopped_early;
  logic [31:0]        final_loss;
  logic               error_flag;
  logic               last_result;
  modport source (output valid, coefficient, coefficient_index, epochs_used,
                  stopped_early, final_loss, error_flag, last_result, input ready);
  modport sink (input valid, coefficient, coefficient_index, epochs_used,
                stopped_early, final_loss, error_flag, last_result, output ready);
endinterface
`default_nettype wire

>>> design/lrgd_cell.sv
// One cell of the chain: holds a weight, its gradient sum and the current feature.
`default_nettype none
module lrgd_cell (
  input  wire logic               clk,
  input  wire lrgd_pkg::cell_ctrl_t ctrl,
  input  wire logic signed [31:0] err_val,
  input  wire logic signed [31:0] x_in,
  input  wire logic signed [47:0] p_in,
  input  wire logic signed [31:0] w_in,
  input  wire logic signed [63:0] g_in,
  output logic signed [31:0]      x_q,
  output logic signed [47:0]      p_q,
  output logic signed [31:0]      w_q,
  output logic signed [63:0]      g_q
);

  logic signed [31:0] x_r, w_r;
  logic signed [47:0] p_r;
  logic signed [63:0] g_r;
  logic signed [63:0] xw_full, ex_full;

  assign xw_full = x_r * w_r;
  assign ex_full = err_val * x_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift_x) begin
      x_r <= x_in;
    end
    // Products are floored to Q32.16 on the way into the register.
    if (ctrl.mul) begin
      p_r <= 48'(xw_full >>> 16);
    end else if (ctrl.shift_p) begin
      p_r <= p_in;
    end
    if (ctrl.clear_w) begin
      w_r <= '0;
    end else if (ctrl.shift_wg) begin
      w_r <= w_in;
    end
    if (ctrl.clear_g) begin
      g_r <= '0;
    end else if (ctrl.grad) begin
      g_r <= g_r + (ex_full >>> 16);
    end else if (ctrl.shift_wg) begin
      g_r <= g_in;
    end
  end

  assign x_q = x_r;
  assign p_q = p_r;
  assign w_q = w_r;
  assign g_q = g_r;

endmodule
`default_nettype wire

>>> design/lrgd_div.sv
// Restoring divider: signed 64-bit dividend by an unsigned count, one bit a cycle.
`default_nettype none
module lrgd_div #(
  parameter int DIV_W = 11
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [DIV_W-1:0]   divisor,
  output logic                    busy,
  output logic                    done,
  output logic signed [63:0]      quotient
);

  logic             busy_r, done_r, neg_r;
  logic [6:0]       cnt_r;
  logic [63:0]      q_r, quo_r, mag, q_next;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W:0]   rem_sh, rem_diff;
  logic             ge;

  assign mag      = dividend[63] ? 64'(-dividend) : 64'(dividend);
  assign rem_sh   = {rem_r, q_r[63]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign q_next   = {q_r[62:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r <= dividend[63];
        cnt_r <= '0;
        rem_r <= '0;
        q_r   <= mag;
        // A zero sum needs no iterations.
        if (mag == 64'd0) begin
          quo_r  <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        q_r   <= q_next;
        rem_r <= ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quo_r  <= neg_r ? -q_next : q_next;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> design/linear_regression_gradient_descent_unit.sv
// Top level of the batch gradient descent linear regression unit.
// Usage: the input channel carries one feature word per handshake, row by row; row_end
// marks a row's last feature and carries its target, set_end marks the last feature of
// the set and starts training. Loading takes one word per cycle into the feature and
// target memories. After set_end the unit stops taking input, trains, and then sends
// one result word per weight followed by the bias word, which carries last_result,
// epochs_used, stopped_early and final_loss. A set with a row length mismatch or more
// rows or features than the memories hold yields one error word instead.
// Each epoch walks the rows through the cell chain and then runs one division per mean
// (loss, each weight gradient, bias gradient) in the shared bit-serial divider; a zero
// dividend needs no iterations.
// Results leave through an output register; a stalled receiver simply holds the
// current result word and the unit waits. Reset clears the control state and restores
// the register defaults; the memories need no clearing. Configuration writes are taken
// in any cycle and must only happen while the unit is idle.
`default_nettype none
`include "assert_macros.svh"
module linear_regression_gradient_descent_unit #(
  parameter int MAX_FEATURES = 16,
  parameter int MAX_SAMPLES  = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lrgd_in_if.sink                                in_if,
  lrgd_out_if.source                             out_if,
  input  wire logic                              cfg_we,
  input  wire logic [lrgd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lrgd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int MF  = MAX_FEATURES;
  localparam int CW  = $clog2(MF + 1);
  localparam int KW  = $clog2(MF + 2);
  localparam int SW  = $clog2(MAX_SAMPLES + 1);
  localparam int TW  = $clog2(MAX_SAMPLES);
  localparam int AW  = $clog2(MF * MAX_SAMPLES);
  localparam int RBW = $clog2(MF * MAX_SAMPLES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_ERRW, S_INIT, S_EPSTART, S_RD, S_FLUSH, S_PROD, S_SUM,
    S_ERR, S_GRAD, S_DL_GO, S_DL_WAIT, S_DG_GO, S_DG_WAIT, S_STEP_MUL,
    S_STEP_UPD, S_EPEND, S_EMIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [15:0] lr_r, max_epochs_r;
  logic [31:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r         <= lrgd_pkg::LR_RESET;
      max_epochs_r <= lrgd_pkg::EPOCHS_RESET;
      tol_r        <= lrgd_pkg::TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrgd_pkg::CFG_LEARNING_RATE:  lr_r <= cfg_wdata[15:0];
        lrgd_pkg::CFG_MAX_EPOCHS:     max_epochs_r <= cfg_wdata[15:0];
        lrgd_pkg::CFG_LOSS_TOLERANCE: tol_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Loading state.
  logic [CW-1:0]  col_r, fc_r, col_new;
  logic [SW-1:0]  sc_r;
  logic [RBW-1:0] rbl_r;
  logic           err_seen_r;
  logic           in_acc, wr_ok, row_end_i;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign row_end_i   = in_if.row_end || in_if.set_end;
  assign wr_ok       = (col_r < MF) && (sc_r < MAX_SAMPLES);
  assign col_new     = wr_ok ? col_r + CW'(1) : col_r;

  // Sample memories: one write port for loading, one registered read port for training.
  logic signed [31:0] feat_mem [0:MF*MAX_SAMPLES-1];
  logic signed [31:0] tgt_mem  [0:MAX_SAMPLES-1];
  logic signed [31:0] feat_q_r, tgt_q_r;
  logic               feat_we, tgt_we;
  logic [AW-1:0]      feat_waddr, feat_raddr;
  logic [KW-1:0]      k_r;
  logic [RBW-1:0]     rbt_r;
  logic [SW-1:0]      row_idx_r;

  assign feat_we    = in_acc && wr_ok;
  assign tgt_we     = in_acc && row_end_i && (sc_r < MAX_SAMPLES);
  assign feat_waddr = AW'(rbl_r + RBW'(col_r));
  assign feat_raddr = AW'(rbt_r + RBW'(k_r));

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[feat_waddr] <= in_if.feature_value;
    end
    feat_q_r <= feat_mem[feat_raddr];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[TW'(sc_r)] <= in_if.target_value;
    end
    tgt_q_r <= tgt_mem[TW'(row_idx_r)];
  end

  // Cell chain: features, products, weights and gradient sums all move toward cell 0.
  lrgd_pkg::cell_ctrl_t ctrl;
  logic signed [31:0] x_q [MF];
  logic signed [31:0] w_q [MF];
  logic signed [47:0] p_q [MF];
  logic signed [63:0] g_q [MF];
  logic signed [31:0] x_nb [MF];
  logic signed [31:0] w_nb [MF];
  logic signed [47:0] p_nb [MF];
  logic signed [63:0] g_nb [MF];
  logic signed [31:0] x_feed, w_feed, e_r;

  for (genvar j = 0; j < MF; j++) begin : g_cell
    if (j == MF - 1) begin : g_tail
      assign x_nb[j] = x_feed;
      assign w_nb[j] = w_feed;
      assign p_nb[j] = '0;
      assign g_nb[j] = '0;
    end else begin : g_body
      assign x_nb[j] = x_q[j+1];
      assign w_nb[j] = w_q[j+1];
      assign p_nb[j] = p_q[j+1];
      assign g_nb[j] = g_q[j+1];
    end
    lrgd_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .err_val (e_r),
      .x_in    (x_nb[j]),
      .p_in    (p_nb[j]),
      .w_in    (w_nb[j]),
      .g_in    (g_nb[j]),
      .x_q     (x_q[j]),
      .p_q     (p_q[j]),
      .w_q     (w_q[j]),
      .g_q     (g_q[j])
    );
  end

  // Feature read pipeline: the word read in one cycle shifts into the chain the next.
  // Columns beyond the feature count enter as zero so their cells stay neutral.
  logic rd_vld_r, rd_mask_r;
  assign x_feed = rd_mask_r ? feat_q_r : 32'sd0;

  // Training datapath.
  logic signed [63:0] acc_r, bsum_r;
  logic [63:0]        loss_r;
  logic signed [31:0] bias_r, pred_s, old_val, new_val;
  logic [31:0]        mse_r, prev_r, loss_diff;
  logic [15:0]        epoch_r;
  logic               early_r;
  logic [CW-1:0]      uc_r;
  logic signed [47:0] mean_r;
  logic [39:0]        plo_r;
  logic signed [40:0] phi_r;
  logic signed [63:0] e_sq, phi_ext, step_full, step_q, diff_full;

  assign pred_s    = lrgd_pkg::sat32(acc_r);
  assign e_sq      = e_r * e_r;
  assign old_val   = (uc_r < MF) ? w_q[0] : bias_r;
  assign phi_ext   = {{23{phi_r[40]}}, phi_r};
  assign step_full = (phi_ext <<< 24) + $signed({24'd0, plo_r});
  assign step_q    = step_full >>> 16;
  assign diff_full = {{32{old_val[31]}}, old_val} - step_q;
  assign new_val   = lrgd_pkg::sat32(diff_full);
  assign loss_diff = (mse_r > prev_r) ? mse_r - prev_r : prev_r - mse_r;
  assign w_feed    = (state_r == S_STEP_UPD) ? new_val : 32'sd0;

  // Shared divider for the mean loss and the mean gradients.
  logic               div_start, div_busy, div_done;
  logic signed [63:0] div_dividend, div_quo;

  assign div_start    = (state_r == S_DL_GO) || (state_r == S_DG_GO);
  assign div_dividend = (state_r == S_DL_GO) ? $signed(loss_r) :
                        ((uc_r < MF) ? g_q[0] : bsum_r);

  lrgd_div #(.DIV_W(SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sc_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Output register.
  logic               out_valid_r, out_free;
  logic signed [31:0] o_coef_r;
  logic [6:0]         o_idx_r;
  logic [15:0]        o_epochs_r;
  logic               o_early_r, o_err_r, o_last_r;
  logic [31:0]        o_loss_r;

  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    ctrl         = '0;
    ctrl.shift_x = rd_vld_r;
    case (state_r)
      S_INIT:     ctrl.clear_w = 1'b1;
      S_EPSTART:  ctrl.clear_g = 1'b1;
      S_PROD:     ctrl.mul = 1'b1;
      S_SUM:      ctrl.shift_p = 1'b1;
      S_GRAD:     ctrl.grad = 1'b1;
      S_STEP_UPD: ctrl.shift_wg = (uc_r < MF);
      S_EMIT:     ctrl.shift_wg = out_free && (k_r < fc_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      fc_r        <= '0;
      sc_r        <= '0;
      rbl_r       <= '0;
      err_seen_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r  <= (state_r == S_RD);
      rd_mask_r <= (k_r < fc_r);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!wr_ok) begin
              err_seen_r <= 1'b1;
            end
            if (row_end_i) begin
              if (sc_r >= MAX_SAMPLES) begin
                err_seen_r <= 1'b1;
              end else begin
                if (sc_r == '0) begin
                  fc_r <= col_new;
                end else if (col_new != fc_r) begin
                  err_seen_r <= 1'b1;
                end
                sc_r  <= sc_r + SW'(1);
                rbl_r <= rbl_r + RBW'(MF);
              end
              col_r <= '0;
            end else begin
              col_r <= col_new;
            end
            if (in_if.set_end) begin
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (err_seen_r || fc_r == '0 || sc_r == '0) begin
            state_r <= S_ERRW;
          end else begin
            state_r <= S_INIT;
          end
        end
        S_ERRW: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_coef_r    <= '0;
            o_idx_r     <= '0;
            o_epochs_r  <= '0;
            o_early_r   <= 1'b0;
            o_loss_r    <= '0;
            o_err_r     <= 1'b1;
            o_last_r    <= 1'b1;
            k_r         <= KW'(fc_r) + KW'(1);
            state_r     <= S_EMIT;
          end
        end
        S_INIT: begin
          bias_r  <= '0;
          prev_r  <= '0;
          epoch_r <= '0;
          early_r <= 1'b0;
          k_r     <= '0;
          state_r <= (max_epochs_r == 16'd0) ? S_EMIT : S_EPSTART;
        end
        S_EPSTART: begin
          loss_r    <= '0;
          bsum_r    <= '0;
          row_idx_r <= '0;
          rbt_r     <= '0;
          k_r       <= '0;
          state_r   <= S_RD;
        end
        S_RD: begin
          if (k_r == KW'(MF - 1)) begin
            state_r <= S_FLUSH;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_FLUSH: begin
          state_r <= S_PROD;
        end
        S_PROD: begin
          acc_r   <= {{32{bias_r[31]}}, bias_r};
          k_r     <= '0;
          state_r <= S_SUM;
        end
        S_SUM: begin
          acc_r <= acc_r + {{16{p_q[0][47]}}, p_q[0]};
          if (k_r == KW'(MF - 1)) begin
            state_r <= S_ERR;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_ERR: begin
          e_r     <= lrgd_pkg::sat32({{32{pred_s[31]}}, pred_s} -
                                     {{32{tgt_q_r[31]}}, tgt_q_r});
          state_r <= S_GRAD;
        end
        S_GRAD: begin
          loss_r <= loss_r + ($unsigned(e_sq) >> 16);
          bsum_r <= bsum_r + {{32{e_r[31]}}, e_r};
          k_r    <= '0;
          if (row_idx_r == sc_r - SW'(1)) begin
            state_r <= S_DL_GO;
          end else begin
            row_idx_r <= row_idx_r + SW'(1);
            rbt_r     <= rbt_r + RBW'(MF);
            state_r   <= S_RD;
          end
        end
        S_DL_GO: begin
          state_r <= S_DL_WAIT;
        end
        S_DL_WAIT: begin
          if (div_done) begin
            mse_r   <= (div_quo[63:32] != 32'd0) ? 32'hFFFFFFFF : div_quo[31:0];
            uc_r    <= '0;
            state_r <= S_DG_GO;
          end
        end
        S_DG_GO: begin
          state_r <= S_DG_WAIT;
        end
        S_DG_WAIT: begin
          if (div_done) begin
            mean_r  <= div_quo[47:0];
            state_r <= S_STEP_MUL;
          end
        end
        S_STEP_MUL: begin
          // The 16 x 48 step product is split into two partial products.
          plo_r   <= lr_r * mean_r[23:0];
          phi_r   <= $signed({1'b0, lr_r}) * $signed(mean_r[47:24]);
          state_r <= S_STEP_UPD;
        end
        S_STEP_UPD: begin
          if (uc_r < MF) begin
            uc_r    <= uc_r + CW'(1);
            state_r <= S_DG_GO;
          end else begin
            bias_r  <= new_val;
            state_r <= S_EPEND;
          end
        end
        S_EPEND: begin
          prev_r  <= mse_r;
          epoch_r <= epoch_r + 16'd1;
          if ((epoch_r != 16'd0) && (loss_diff < tol_r)) begin
            early_r <= 1'b1;
            k_r     <= '0;
            state_r <= S_EMIT;
          end else if (epoch_r + 16'd1 < max_epochs_r) begin
            state_r <= S_EPSTART;
          end else begin
            k_r     <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (k_r < fc_r) begin
              out_valid_r <= 1'b1;
              o_coef_r    <= w_q[0];
              o_idx_r     <= 7'(k_r);
              o_epochs_r  <= '0;
              o_early_r   <= 1'b0;
              o_loss_r    <= '0;
              o_err_r     <= 1'b0;
              o_last_r    <= 1'b0;
              k_r         <= k_r + KW'(1);
            end else if (k_r == KW'(fc_r)) begin
              out_valid_r <= 1'b1;
              o_coef_r    <= bias_r;
              o_idx_r     <= 7'(k_r);
              o_epochs_r  <= epoch_r;
              o_early_r   <= early_r;
              o_loss_r    <= prev_r;
              o_err_r     <= 1'b0;
              o_last_r    <= 1'b1;
              k_r         <= k_r + KW'(1);
            end else begin
              // Last word delivered: clear the loading state for the next set.
              out_valid_r <= 1'b0;
              col_r       <= '0;
              fc_r        <= '0;
              sc_r        <= '0;
              rbl_r       <= '0;
              err_seen_r  <= 1'b0;
              state_r     <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.coefficient       = o_coef_r;
  assign out_if.coefficient_index = o_idx_r;
  assign out_if.epochs_used       = o_epochs_r;
  assign out_if.stopped_early     = o_early_r;
  assign out_if.final_loss        = o_loss_r;
  assign out_if.error_flag        = o_err_r;
  assign out_if.last_result       = o_last_r;

  // Input is only taken once every result word of the previous set has left.
  `LRGD_NEVER(a_in_while_out, clk, rst_n, in_if.ready && out_if.valid, "input taken while a result is pending")
  // An error word is always the only, and so the last, word of its set.
  `LRGD_ASSERT(a_err_last, clk, rst_n, out_if.valid && out_if.error_flag |-> out_if.last_result, "error word without last_result")
  // An epoch only ends while the epoch count is still below the limit.
  `LRGD_ASSERT(a_epoch_bound, clk, rst_n, (state_r == S_EPEND) |-> (epoch_r < max_epochs_r), "epoch run beyond the limit")
  // The divider only works while the sequencer waits for it.
  `LRGD_ASSERT(a_div_wait, clk, rst_n, div_busy |-> (state_r == S_DL_WAIT || state_r == S_DG_WAIT), "divider busy outside a wait state")

endmodule
`default_nettype wire
